/* rtl/sdod_pkg.sv */
// Shared types and constants for the sudden drop obstacle detector.
package sdod_pkg;

   localparam int TIME_BITS = 32;
   localparam int CM_BITS   = 16;
   localparam int MS_BITS   = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DROP_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CONFIRM_HOLD   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_REAL       = 2'd2;

   localparam logic [CM_BITS-1:0] DROP_THRESHOLD_RESET = 16'd500;
   localparam logic [MS_BITS-1:0] CONFIRM_HOLD_RESET   = 16'd2000;
   localparam logic [CM_BITS-1:0] MAX_REAL_RESET       = 16'd4500;

   typedef enum logic [1:0] {
      PAGE_NONE    = 2'd0,
      PAGE_NORMAL  = 2'd1,
      PAGE_WARNING = 2'd2
   } page_type;

   typedef struct packed {
      logic [31:0]        now_ms;
      logic [CM_BITS-1:0] sample_cm;
      logic               session_active;
   } req_type;

   typedef struct packed {
      logic     warning_on;
      page_type page_command;
   } rsp_type;

   typedef struct packed {
      logic [CM_BITS-1:0] drop_threshold_cm;
      logic [MS_BITS-1:0] confirm_hold_ms;
      logic [CM_BITS-1:0] max_real_cm;
   } cfg_type;

endpackage

/* rtl/sudden_drop_obstacle_detector.sv */
// Top level of the sudden drop obstacle detector: handshake, input and result registers.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | req_payload (req_type)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_payload (rsp_type)
//   csr     | in        | csr_write              | csr_index, csr_data
//
// One tick per clock cycle while the result is not stalled; a result passes through the
// input register and then the result register. The input register feeds the state
// update, which writes the result register. Reset is synchronous and restores the default
// thresholds and clears the valid flags and detector state. A stalled result holds both
// registers; the input register still takes a transfer while it is empty.
module sudden_drop_obstacle_detector
   import sdod_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_payload,
   input  logic                     csr_write,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   cfg_type cfg;
   req_type item_ff;
   logic    item_valid_ff;
   rsp_type result;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    advance;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   sdod_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sdod_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/sdod_csr.sv */
// Configuration register file for the sudden drop obstacle detector.
module sdod_csr
   import sdod_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_DROP_THRESHOLD: cfg_in.drop_threshold_cm = csr_data;
            CSR_CONFIRM_HOLD:   cfg_in.confirm_hold_ms   = csr_data;
            CSR_MAX_REAL:       cfg_in.max_real_cm       = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drop_threshold_cm <= DROP_THRESHOLD_RESET;
         cfg_ff.confirm_hold_ms   <= CONFIRM_HOLD_RESET;
         cfg_ff.max_real_cm       <= MAX_REAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/sdod_core.sv */
// Detector state and per-tick update logic.
module sdod_core
   import sdod_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic [CM_BITS-1:0]   last_ff, last_in;
   logic                 base_ff, base_in;
   logic                 pend_ff, pend_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic                 warn_ff, warn_in;
   page_type             page;

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] elapsed;
   logic [CM_BITS-1:0]   cur;
   logic [CM_BITS-1:0]   fall;
   logic [CM_BITS-1:0]   climb;
   logic                 real_prev;
   logic                 drop;
   logic                 rise;

   assign now_t     = TIME_BITS'(item.now_ms);
   assign cur       = item.sample_cm;
   assign fall      = last_ff - cur;
   assign climb     = cur - last_ff;
   assign real_prev = last_ff <= cfg.max_real_cm;
   assign drop      = real_prev && (last_ff > cur) && (fall >= cfg.drop_threshold_cm);
   assign rise      = real_prev && (cur > last_ff) && (climb >= cfg.drop_threshold_cm);
   assign elapsed   = now_t - start_in;

   always_comb begin
      last_in  = last_ff;
      base_in  = base_ff;
      pend_in  = pend_ff;
      start_in = start_ff;
      warn_in  = warn_ff;
      page     = PAGE_NONE;
      if (!item.session_active) begin
         base_in = 1'b0;
         pend_in = 1'b0;
         warn_in = 1'b0;
      end else begin
         if (!base_ff) begin
            last_in = cur;
            base_in = 1'b1;
         end else if (cur != last_ff) begin
            if (warn_ff) begin
               if (rise) begin
                  warn_in = 1'b0;
                  page    = PAGE_NORMAL;
               end
            end else if (pend_ff) begin
               if (rise) begin
                  pend_in = 1'b0;
               end
            end else if (drop) begin
               pend_in  = 1'b1;
               start_in = now_t;
            end
            last_in = cur;
         end
         if (pend_in && (elapsed >= TIME_BITS'(cfg.confirm_hold_ms))) begin
            warn_in = 1'b1;
            pend_in = 1'b0;
            page    = PAGE_WARNING;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         base_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         start_ff <= '0;
         warn_ff  <= 1'b0;
      end else if (advance) begin
         last_ff  <= last_in;
         base_ff  <= base_in;
         pend_ff  <= pend_in;
         start_ff <= start_in;
         warn_ff  <= warn_in;
      end
   end

   assign result.warning_on   = warn_in;
   assign result.page_command = page;

`ifndef SYNTH
   a_warn_pend_excl: assert property (@(posedge clock) disable iff (reset)
      !(warn_ff && pend_ff))
      else $error("warning and pending hold set together");

   a_pend_needs_base: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> base_ff)
      else $error("pending hold without baseline");

   a_warn_needs_base: assert property (@(posedge clock) disable iff (reset)
      warn_ff |-> base_ff)
      else $error("warning without baseline");

   a_page_matches_warn: assert property (@(posedge clock) disable iff (reset)
      advance |=> ($past(page) != PAGE_WARNING || warn_ff) &&
                  ($past(page) != PAGE_NORMAL || !warn_ff))
      else $error("page command disagrees with warning state");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the sudden drop obstacle detector.
module tb_top;
   import sdod_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 80;

   typedef enum int {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_payload;
   logic                     csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   sudden_drop_obstacle_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #10 clock = ~clock;

   // detector state as predicted
   logic [CM_BITS-1:0] thr_cm, lim_cm, last_cm;
   logic [MS_BITS-1:0] hold_ms;
   logic               has_base, hold_armed, warn_up;
   logic [31:0]        hold_since;

   req_type  tick_queue[$];
   rsp_type  warning_due[$];
   flow_type flow = FLOW_FREE;
   logic     req_sent = 1'b0;
   logic     long_hold_req = 1'b0;
   logic     long_hold_done = 1'b0;
   int       hold_left = 0;
   int       fault_count = 0;
   int       ticks_taken = 0;
   int       results_seen = 0;
   int       warnings_raised = 0;
   int       warnings_cleared = 0;
   int       settings_run = 1;
   int       cycles = 0;
   logic [31:0]        gen_now;
   logic [CM_BITS-1:0] gen_dist;

   function automatic rsp_type predict_warning(input req_type t);
      rsp_type            r;
      page_type           page;
      logic [CM_BITS-1:0] prev;
      logic               prev_ok, drop, rise;
      page = PAGE_NONE;
      if (!t.session_active) begin
         has_base = 1'b0;
         hold_armed = 1'b0;
         warn_up = 1'b0;
         r.warning_on = 1'b0;
         r.page_command = PAGE_NONE;
         return r;
      end
      if (!has_base) begin
         last_cm = t.sample_cm;
         has_base = 1'b1;
      end else if (t.sample_cm != last_cm) begin
         prev = last_cm;
         prev_ok = prev <= lim_cm;
         drop = prev_ok && prev > t.sample_cm && (prev - t.sample_cm) >= thr_cm;
         rise = prev_ok && t.sample_cm > prev && (t.sample_cm - prev) >= thr_cm;
         if (warn_up) begin
            if (rise) begin
               warn_up = 1'b0;
               page = PAGE_NORMAL;
            end
         end else if (hold_armed) begin
            if (rise)
               hold_armed = 1'b0;
         end else if (drop) begin
            hold_armed = 1'b1;
            hold_since = t.now_ms;
         end
         last_cm = t.sample_cm;
      end
      if (hold_armed && (t.now_ms - hold_since) >= {16'd0, hold_ms}) begin
         warn_up = 1'b1;
         hold_armed = 1'b0;
         page = PAGE_WARNING;
      end
      r.warning_on = warn_up;
      r.page_command = page;
      return r;
   endfunction

   // monitor: track register writes, predict on each input transfer, check each result
   always @(posedge clock) begin
      rsp_type want;
      req_sent <= req_valid && req_ready;
      if (reset) begin
         thr_cm = DROP_THRESHOLD_RESET;
         hold_ms = CONFIRM_HOLD_RESET;
         lim_cm = MAX_REAL_RESET;
         last_cm = '0;
         has_base = 1'b0;
         hold_armed = 1'b0;
         hold_since = '0;
         warn_up = 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_DROP_THRESHOLD: thr_cm = csr_data;
               CSR_CONFIRM_HOLD:   hold_ms = csr_data;
               CSR_MAX_REAL:       lim_cm = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            warning_due.push_back(predict_warning(req_payload));
            ticks_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_payload.page_command == PAGE_WARNING)
               warnings_raised++;
            if (rsp_payload.page_command == PAGE_NORMAL)
               warnings_cleared++;
            if (warning_due.size() == 0) begin
               $display("%0t: result with none expected, actual %p", $time, rsp_payload);
               fault_count++;
            end else begin
               want = warning_due.pop_front();
               if (rsp_payload.warning_on !== want.warning_on) begin
                  $display("%0t: warning_on expected %0b actual %0b",
                           $time, want.warning_on, rsp_payload.warning_on);
                  fault_count++;
               end
               if (rsp_payload.page_command !== want.page_command) begin
                  $display("%0t: page_command expected %0d actual %0d",
                           $time, want.page_command, rsp_payload.page_command);
                  fault_count++;
               end
            end
         end
      end
   end

   // driver: hold the payload until transfer, then advance
   always @(negedge clock) begin
      logic idle;
      idle = (flow == FLOW_SENDER_IDLE && $urandom_range(99) < 83) ||
             (flow == FLOW_BOTH && $urandom_range(99) < 19);
      if (reset)
         req_valid <= 1'b0;
      else if (!req_valid || req_sent) begin
         if (tick_queue.size() != 0 && !idle) begin
            req_payload <= tick_queue.pop_front();
            req_valid <= 1'b1;
         end else
            req_valid <= 1'b0;
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      logic stall;
      stall = (flow == FLOW_RECEIVER_STALL && $urandom_range(99) < 83) ||
              (flow == FLOW_BOTH && $urandom_range(99) < 19);
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (long_hold_req && !long_hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD;
         long_hold_done <= 1'b1;
      end else
         rsp_ready <= !stall;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_type gen_tick(input logic [15:0] thr, input logic [15:0] hold,
                                        input logic [15:0] lim);
      req_type t;
      int      d, room;
      case ($urandom_range(9))
         0:       gen_now += 0;
         1, 2:    gen_now += $urandom_range(hold / 4);
         3:       gen_now += hold - 1;
         4:       gen_now += hold;
         5:       gen_now += hold + 1;
         6, 7:    gen_now += $urandom_range(2 * hold + 8);
         8:       gen_now += $urandom();
         default: gen_now += $urandom_range(50);
      endcase
      d = int'(gen_dist);
      case ($urandom_range(11))
         0, 1: ;
         2, 3: begin
            if (d >= thr) begin
               room = (d - thr > 200) ? 200 : d - thr;
               d = d - thr - $urandom_range(room);
            end else
               d = $urandom_range(d);
         end
         4, 5: begin
            if (65535 - d >= thr) begin
               room = (65535 - d - thr > 200) ? 200 : 65535 - d - thr;
               d = d + thr + $urandom_range(room);
            end else
               d = $urandom_range(65535, d);
         end
         6:  d = ($urandom_range(1)) ? d + thr - 1 : d - thr + 1;
         7:  d = $urandom_range(65535);
         8:  d = lim + $urandom_range(50, 1);
         9:  d = $urandom_range(lim);
         default: d = d + $urandom_range(6) - 3;
      endcase
      if (d < 0)
         d = 0;
      if (d > 65535)
         d = 65535;
      gen_dist = CM_BITS'(d);
      t.now_ms = gen_now;
      t.sample_cm = gen_dist;
      t.session_active = ($urandom_range(39) != 0);
      return t;
   endfunction

   task automatic drain;
      do
         @(negedge clock);
      while (tick_queue.size() != 0 || req_valid || warning_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
   endtask

   task automatic run_setting(input logic [15:0] thr, input logic [15:0] hold,
                              input logic [15:0] lim, input flow_type mode,
                              input int count);
      drain();
      write_reg(CSR_DROP_THRESHOLD, thr);
      write_reg(CSR_CONFIRM_HOLD, hold);
      write_reg(CSR_MAX_REAL, lim);
      write_reg(CSR_UNUSED, CSR_DATA_BITS'($urandom()));
      @(negedge clock);
      csr_write <= 1'b0;
      flow = mode;
      settings_run++;
      gen_dist = CM_BITS'($urandom_range(lim));
      gen_now = $urandom();
      repeat (count) tick_queue.push_back(gen_tick(thr, hold, lim));
   endtask

   function automatic req_type mk(input logic [31:0] now, input logic [15:0] sample,
                                  input logic active);
      req_type t;
      t.now_ms = now;
      t.sample_cm = sample;
      t.session_active = active;
      return t;
   endfunction

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      // reset thresholds: baseline, drop, confirm, rise, cancel, unreal baseline, wrap
      tick_queue.push_back(mk(32'd0, 16'd0, 1'b0));
      tick_queue.push_back(mk(32'd100, 16'd3000, 1'b1));
      tick_queue.push_back(mk(32'd200, 16'd3000, 1'b1));
      tick_queue.push_back(mk(32'd300, 16'd2400, 1'b1));
      tick_queue.push_back(mk(32'd1000, 16'd2400, 1'b1));
      tick_queue.push_back(mk(32'd2300, 16'd2400, 1'b1));
      tick_queue.push_back(mk(32'd2400, 16'd1000, 1'b1));
      tick_queue.push_back(mk(32'd2500, 16'd1600, 1'b1));
      tick_queue.push_back(mk(32'd2600, 16'd1000, 1'b1));
      tick_queue.push_back(mk(32'd2700, 16'd1600, 1'b1));
      tick_queue.push_back(mk(32'd2800, 16'd65535, 1'b1));
      tick_queue.push_back(mk(32'd2900, 16'd0, 1'b1));
      tick_queue.push_back(mk(32'hFFFF_FF00, 16'd4500, 1'b1));
      tick_queue.push_back(mk(32'hFFFF_FF10, 16'd3900, 1'b1));
      tick_queue.push_back(mk(32'h0000_0700, 16'd3900, 1'b1));
      tick_queue.push_back(mk(32'hFFFF_FFFF, 16'd3900, 1'b1));
      tick_queue.push_back(mk(32'd0, 16'd0, 1'b0));
      tick_queue.push_back(mk(32'd5, 16'd4600, 1'b1));
      tick_queue.push_back(mk(32'd6, 16'd4000, 1'b1));
      tick_queue.push_back(mk(32'd7, 16'd3400, 1'b1));

      run_setting(16'd0, 16'd0, 16'd65535, FLOW_FREE, 150);
      long_hold_req <= 1'b1;
      run_setting(16'd65535, 16'd65535, 16'd0, FLOW_SENDER_IDLE, 150);
      run_setting(16'd300, 16'd100, 16'd4500, FLOW_RECEIVER_STALL, 300);
      run_setting(16'd1, 16'd1, 16'd1000, FLOW_BOTH, 200);
      run_setting(CM_BITS'($urandom_range(2000, 1)), MS_BITS'($urandom_range(3000)),
                  CM_BITS'($urandom_range(65535, 1000)), FLOW_FREE, 400);
      drain();
      repeat (10) @(negedge clock);

      $display("%0d ticks over %0d register settings gave %0d results", ticks_taken,
               settings_run, results_seen);
      $display("warning page commanded %0d times, normal page %0d times", warnings_raised,
               warnings_cleared);
      if (fault_count == 0 && warning_due.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sudden_drop_obstacle_detector.f */
rtl/sdod_pkg.sv
rtl/sdod_csr.sv
rtl/sdod_core.sv
rtl/sudden_drop_obstacle_detector.sv
tb/sv/tb_top.sv
